### design/cfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared widths, register codes, reset values, stage types and the divider
// step for the car-following acceleration pipeline.
// ----------------------------------------------------------------------------
package cfa_pkg;

   // Fixed-point formats.
   localparam int FRAC       = 16;
   localparam int TIME_FRAC  = 12;
   localparam int NOISE_FRAC = 16;

   // Field widths.
   localparam int GAP_W  = 26;
   localparam int SPD_W  = 22;
   localparam int TS_W   = 16;
   localparam int NS_W   = 16;
   localparam int ACC_W  = 24;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 26;

   // Internal widths.
   localparam int QUO_W = 31;   // ratio quotient bits below the saturation cap
   localparam int DIV_W = 58;   // partial remainder and shifted divisor
   localparam int SK_W  = 36;   // desired gaps
   localparam int SQ_W  = 40;   // saturated squares
   localparam int NZ_W  = 26;   // scaled noise term
   localparam int DM_W  = 28;   // damping term
   localparam int ZA_W  = 29;   // acceleration inside the zone
   localparam int T_W   = 37;   // clamped driver bracket
   localparam int T_LO  = 18;   // low part of the split multiply
   localparam int IDM_W = 42;   // final acceleration before clamping

   // Pipeline depth from the input transfer to the result strobe.
   localparam int FRONT_STAGES = 4;
   localparam int BACK_STAGES  = 6;
   localparam int PIPE_LAT     = FRONT_STAGES + QUO_W + BACK_STAGES;

   // Register indexes.
   typedef enum logic [CSR_AW-1:0] {
      REG_TIME_GAP      = 3'd0,
      REG_ZONE_LOW_GAP  = 3'd1,
      REG_ZONE_HIGH_GAP = 3'd2,
      REG_MINIMUM_GAP   = 3'd3,
      REG_MAX_ACCEL     = 3'd4,
      REG_BRAKE_TERM    = 3'd5,
      REG_NOISE_GAIN    = 3'd6,
      REG_DAMPING       = 3'd7
   } cfa_reg_type;

   // Register reset values.
   localparam logic [15:0] RST_TIME_GAP      = 16'd6144;
   localparam logic [15:0] RST_ZONE_LOW_GAP  = 16'd4096;
   localparam logic [15:0] RST_ZONE_HIGH_GAP = 16'd8192;
   localparam logic [25:0] RST_MINIMUM_GAP   = 26'd131072;
   localparam logic [19:0] RST_MAX_ACCEL     = 20'd65536;
   localparam logic [19:0] RST_BRAKE_TERM    = 20'd26755;
   localparam logic [23:0] RST_NOISE_GAIN    = 24'd0;
   localparam logic [19:0] RST_DAMPING       = 20'd0;

   // Configuration register set.
   typedef struct packed {
      logic [15:0] time_gap;
      logic [15:0] zone_low_time_gap;
      logic [15:0] zone_high_time_gap;
      logic [25:0] minimum_gap;
      logic [19:0] max_acceleration;
      logic [19:0] brake_term;
      logic [23:0] noise_gain;
      logic [19:0] damping;
   } cfa_cfg_type;

   // One lane of the restoring divider.
   typedef struct packed {
      logic [DIV_W-1:0] rem;
      logic [GAP_W-1:0] den;
      logic [QUO_W-1:0] quo;
      logic             ovf;
   } cfa_lane_type;

   // Values that ride alongside the divider.
   typedef struct packed {
      logic                   zone;
      logic                   zero;
      logic signed [NZ_W-1:0] noise;
      logic signed [DM_W-1:0] damp;
   } cfa_side_type;

   // One restoring step: try the divisor shifted to quotient bit sh.
   function automatic cfa_lane_type cfa_div_step(cfa_lane_type lane, int sh);
      cfa_lane_type     res;
      logic [DIV_W-1:0] trial;
      res   = lane;
      trial = DIV_W'(lane.den) << sh;
      if (lane.rem >= trial) begin
         res.rem = lane.rem - trial;
         res.quo[sh] = 1'b1;
      end
      return res;
   endfunction

endpackage

### design/cfa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfa_front
// Four-stage front end: approach rate, braking term, the three desired gaps,
// the zone test and the setup of both ratio divisions.
// ----------------------------------------------------------------------------
module cfa_front (
   input  logic                        clock,
   input  logic                        reset,
   input  cfa_pkg::cfa_cfg_type        cfg,
   input  logic                        in_valid,
   input  logic [cfa_pkg::GAP_W-1:0]   gap,
   input  logic [cfa_pkg::SPD_W-1:0]   speed,
   input  logic [cfa_pkg::SPD_W-1:0]   leader_speed,
   input  logic [cfa_pkg::SPD_W-1:0]   desired_speed,
   input  logic [cfa_pkg::TS_W-1:0]    time_scale,
   input  logic [cfa_pkg::NS_W-1:0]    noise_sample,
   output logic                        out_valid,
   output cfa_pkg::cfa_lane_type       lane_v,
   output cfa_pkg::cfa_lane_type       lane_s,
   output cfa_pkg::cfa_side_type       side
);

   localparam int GW = cfa_pkg::GAP_W;
   localparam int SW = cfa_pkg::SPD_W;
   localparam int KW = cfa_pkg::SK_W;

   // Stage 1: approach rate, speed times approach rate, local headways.
   logic                valid1_ff;
   logic [GW-1:0]       s1_ff;
   logic [SW-1:0]       v1_ff, v01_ff;
   logic [15:0]         ns1_ff;
   logic signed [SW:0]  dv1_ff, dv1_in;
   logic signed [2*SW+1:0] vdv;
   logic signed [29:0]  m1_ff;
   logic [31:0]         tl0_ff, tl1_ff, tl2_ff;

   assign dv1_in = $signed({1'b0, speed}) - $signed({1'b0, leader_speed});
   assign vdv    = $signed({1'b0, speed}) * dv1_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff  <= gap;
      v1_ff  <= speed;
      v01_ff <= desired_speed;
      ns1_ff <= noise_sample;
      dv1_ff <= dv1_in;
      m1_ff  <= vdv[2*SW+1:cfa_pkg::FRAC];
      tl0_ff <= cfg.time_gap * time_scale;
      tl1_ff <= cfg.zone_low_time_gap * time_scale;
      tl2_ff <= cfg.zone_high_time_gap * time_scale;
   end

   // Stage 2: braking term, headway distances, noise and damping products.
   logic                valid2_ff;
   logic [GW-1:0]       s2_ff;
   logic [SW-1:0]       v2_ff, v02_ff;
   logic signed [50:0]  brk_prod;
   logic signed [34:0]  brk2_ff;
   logic [53:0]         hp0, hp1, hp2;
   logic [29:0]         hw0_ff, hw1_ff, hw2_ff;
   logic signed [16:0]  nr;
   logic signed [41:0]  noise_prod;
   logic signed [43:0]  damp_prod;
   logic signed [cfa_pkg::NZ_W-1:0] noise2_ff;
   logic signed [cfa_pkg::DM_W-1:0] damp2_ff;

   assign brk_prod   = m1_ff * $signed({1'b0, cfg.brake_term});
   assign hp0        = tl0_ff * v1_ff;
   assign hp1        = tl1_ff * v1_ff;
   assign hp2        = tl2_ff * v1_ff;
   assign nr         = $signed({1'b0, ns1_ff}) - 17'sd32768;
   assign noise_prod = $signed({1'b0, cfg.noise_gain}) * nr;
   assign damp_prod  = $signed({1'b0, cfg.damping}) * dv1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else begin
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_ff     <= s1_ff;
      v2_ff     <= v1_ff;
      v02_ff    <= v01_ff;
      brk2_ff   <= brk_prod[50:cfa_pkg::FRAC];
      hw0_ff    <= hp0[53:2*cfa_pkg::TIME_FRAC];
      hw1_ff    <= hp1[53:2*cfa_pkg::TIME_FRAC];
      hw2_ff    <= hp2[53:2*cfa_pkg::TIME_FRAC];
      noise2_ff <= noise_prod[41:cfa_pkg::NOISE_FRAC];
      damp2_ff  <= damp_prod[43:cfa_pkg::FRAC];
   end

   // Stage 3: desired gaps, with the headway plus braking term floored at zero.
   logic                valid3_ff;
   logic [GW-1:0]       s3_ff;
   logic [SW-1:0]       v3_ff, v03_ff;
   logic [KW-1:0]       sk0_ff, sk1_ff, sk2_ff;
   logic signed [cfa_pkg::NZ_W-1:0] noise3_ff;
   logic signed [cfa_pkg::DM_W-1:0] damp3_ff;

   function automatic logic [KW-1:0] desired_gap(logic [29:0] hw,
                                                 logic signed [34:0] brk,
                                                 logic [GW-1:0] mg);
      logic signed [KW-1:0] d;
      logic [KW-1:0]        dpos;
      d    = $signed({6'b0, hw}) + KW'(brk);
      dpos = d[KW-1] ? '0 : KW'(d);
      return dpos + KW'(mg);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
      end else begin
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_ff     <= s2_ff;
      v3_ff     <= v2_ff;
      v03_ff    <= v02_ff;
      sk0_ff    <= desired_gap(hw0_ff, brk2_ff, cfg.minimum_gap);
      sk1_ff    <= desired_gap(hw1_ff, brk2_ff, cfg.minimum_gap);
      sk2_ff    <= desired_gap(hw2_ff, brk2_ff, cfg.minimum_gap);
      noise3_ff <= noise2_ff;
      damp3_ff  <= damp2_ff;
   end

   // Stage 4: zone test, special cases and divider setup.
   logic                  valid4_ff;
   cfa_pkg::cfa_lane_type lane_v_ff, lane_v_in;
   cfa_pkg::cfa_lane_type lane_s_ff, lane_s_in;
   cfa_pkg::cfa_side_type side_ff, side_in;

   always_comb begin
      lane_v_in.rem = {20'b0, v3_ff, 16'b0};
      lane_v_in.den = GW'(v03_ff);
      lane_v_in.quo = '0;
      lane_v_in.ovf = ({15'b0, v3_ff} >= {v03_ff, 15'b0});
      lane_s_in.rem = {6'b0, sk0_ff, 16'b0};
      lane_s_in.den = s3_ff;
      lane_s_in.quo = '0;
      lane_s_in.ovf = ({5'b0, sk0_ff} >= {s3_ff, 15'b0});
      side_in.zone  = (KW'(s3_ff) >= sk1_ff) && (KW'(s3_ff) <= sk2_ff);
      side_in.zero  = (s3_ff == '0) || (v03_ff == '0);
      side_in.noise = noise3_ff;
      side_in.damp  = damp3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
      end else begin
         valid4_ff <= valid3_ff;
      end
   end

   always_ff @(posedge clock) begin
      lane_v_ff <= lane_v_in;
      lane_s_ff <= lane_s_in;
      side_ff   <= side_in;
   end

   assign out_valid = valid4_ff;
   assign lane_v    = lane_v_ff;
   assign lane_s    = lane_s_ff;
   assign side      = side_ff;

endmodule

### design/cfa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfa_div
// Two-lane pipelined restoring divider, one quotient bit per stage, for the
// speed ratio and the gap ratio. Side values travel with each item.
// ----------------------------------------------------------------------------
module cfa_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  cfa_pkg::cfa_lane_type in_lane_v,
   input  cfa_pkg::cfa_lane_type in_lane_s,
   input  cfa_pkg::cfa_side_type in_side,
   output logic                  out_valid,
   output cfa_pkg::cfa_lane_type out_lane_v,
   output cfa_pkg::cfa_lane_type out_lane_s,
   output cfa_pkg::cfa_side_type out_side
);

   localparam int QW = cfa_pkg::QUO_W;

   logic                  valid_ff  [QW];
   cfa_pkg::cfa_lane_type lane_v_ff [QW];
   cfa_pkg::cfa_lane_type lane_s_ff [QW];
   cfa_pkg::cfa_side_type side_ff   [QW];

   // One stage per quotient bit, most significant bit first.
   for (genvar g = 0; g < QW; g++) begin : g_stage
      logic                  src_valid;
      cfa_pkg::cfa_lane_type src_v, src_s;
      cfa_pkg::cfa_side_type src_side;

      if (g == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_v     = in_lane_v;
         assign src_s     = in_lane_s;
         assign src_side  = in_side;
      end else begin : g_next
         assign src_valid = valid_ff[g-1];
         assign src_v     = lane_v_ff[g-1];
         assign src_s     = lane_s_ff[g-1];
         assign src_side  = side_ff[g-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         lane_v_ff[g] <= cfa_pkg::cfa_div_step(src_v, QW - 1 - g);
         lane_s_ff[g] <= cfa_pkg::cfa_div_step(src_s, QW - 1 - g);
         side_ff[g]   <= src_side;
      end
   end

   assign out_valid  = valid_ff[QW-1];
   assign out_lane_v = lane_v_ff[QW-1];
   assign out_lane_s = lane_s_ff[QW-1];
   assign out_side   = side_ff[QW-1];

   // Without overflow the final remainder must be below the divisor.
   a_rem_v : assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_lane_v.ovf |->
         out_lane_v.rem < cfa_pkg::DIV_W'(out_lane_v.den))
      else $error("speed ratio remainder not below divisor");

   a_rem_s : assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_lane_s.ovf |->
         out_lane_s.rem < cfa_pkg::DIV_W'(out_lane_s.den))
      else $error("gap ratio remainder not below divisor");

endmodule

### design/cfa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfa_back
// Six-stage back end: saturated squares, the driver bracket, the split
// multiply by the maximum acceleration, selection and final clamping.
// ----------------------------------------------------------------------------
module cfa_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [19:0]                max_acceleration,
   input  logic                       in_valid,
   input  cfa_pkg::cfa_lane_type      lane_v,
   input  cfa_pkg::cfa_lane_type      lane_s,
   input  cfa_pkg::cfa_side_type      side,
   output logic                       out_valid,
   output logic [cfa_pkg::ACC_W-1:0]  acceleration,
   output logic                       in_zone
);

   localparam int QW  = cfa_pkg::QUO_W;
   localparam int QS  = cfa_pkg::SQ_W;
   localparam int ZW  = cfa_pkg::ZA_W;
   localparam int TW  = cfa_pkg::T_W;
   localparam int TL  = cfa_pkg::T_LO;
   localparam int IW  = cfa_pkg::IDM_W;
   localparam logic [QW-1:0] OPND_CAP = '1;
   localparam logic signed [42:0] T_FLOOR = -(43'sd9 <<< (2 * cfa_pkg::FRAC));
   localparam logic signed [IW-1:0] ACC_FLOOR = -(IW'(9) <<< cfa_pkg::FRAC);
   localparam logic signed [IW-1:0] ACC_CAP = IW'((1 << (cfa_pkg::ACC_W - 1)) - 1);

   // Square with a saturated result.
   function automatic logic [QS-1:0] square_sat(logic [QW-1:0] x);
      logic [2*QW-1:0] sq;
      logic [2*QW-cfa_pkg::FRAC-1:0] sh;
      sq = x * x;
      sh = sq[2*QW-1:cfa_pkg::FRAC];
      return (|sh[2*QW-cfa_pkg::FRAC-1:QS]) ? '1 : sh[QS-1:0];
   endfunction

   // Stage 1: square both ratios, form the zone acceleration.
   logic                   valid1_ff;
   logic [QS-1:0]          sqv1_ff, q1_ff;
   logic                   zone1_ff, zero1_ff;
   logic signed [ZW-1:0]   za1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      sqv1_ff  <= square_sat(lane_v.ovf ? OPND_CAP : lane_v.quo);
      q1_ff    <= square_sat(lane_s.ovf ? OPND_CAP : lane_s.quo);
      zone1_ff <= side.zone;
      zero1_ff <= side.zero;
      za1_ff   <= ZW'(side.noise) - ZW'(side.damp);
   end

   // Stage 2: fourth power of the speed ratio.
   logic                   valid2_ff;
   logic [QS-1:0]          p2_ff, q2_ff;
   logic                   zone2_ff, zero2_ff;
   logic signed [ZW-1:0]   za2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else begin
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      p2_ff    <= square_sat((|sqv1_ff[QS-1:QW]) ? OPND_CAP : sqv1_ff[QW-1:0]);
      q2_ff    <= q1_ff;
      zone2_ff <= zone1_ff;
      zero2_ff <= zero1_ff;
      za2_ff   <= za1_ff;
   end

   // Stage 3: bracket one minus both terms; a bracket below the floor limit
   // already drives any nonzero maximum acceleration under the floor.
   logic                   valid3_ff;
   logic signed [42:0]     t_full;
   logic signed [TW-1:0]   t3_ff;
   logic                   zone3_ff, zero3_ff;
   logic signed [ZW-1:0]   za3_ff;

   assign t_full = (43'sd1 <<< cfa_pkg::FRAC) - $signed({3'b0, p2_ff})
                   - $signed({3'b0, q2_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
      end else begin
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      t3_ff    <= (t_full < T_FLOOR) ? TW'(T_FLOOR) : TW'(t_full);
      zone3_ff <= zone2_ff;
      zero3_ff <= zero2_ff;
      za3_ff   <= za2_ff;
   end

   // Stage 4: low partial product.
   logic                    valid4_ff;
   logic [TL+19:0]          pl4_ff;
   logic signed [TW-TL-1:0] th4_ff;
   logic                    zone4_ff, zero4_ff;
   logic signed [ZW-1:0]    za4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
      end else begin
         valid4_ff <= valid3_ff;
      end
   end

   always_ff @(posedge clock) begin
      pl4_ff   <= max_acceleration * t3_ff[TL-1:0];
      th4_ff   <= t3_ff[TW-1:TL];
      zone4_ff <= zone3_ff;
      zero4_ff <= zero3_ff;
      za4_ff   <= za3_ff;
   end

   // Stage 5: high partial product.
   logic                    valid5_ff;
   logic [TL+19:0]          pl5_ff;
   logic signed [TW-TL+20:0] ph5_ff;
   logic                    zone5_ff, zero5_ff;
   logic signed [ZW-1:0]    za5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid5_ff <= 1'b0;
      end else begin
         valid5_ff <= valid4_ff;
      end
   end

   always_ff @(posedge clock) begin
      ph5_ff   <= $signed({1'b0, max_acceleration}) * th4_ff;
      pl5_ff   <= pl4_ff;
      zone5_ff <= zone4_ff;
      zero5_ff <= zero4_ff;
      za5_ff   <= za4_ff;
   end

   // Stage 6: combine, pick the case, clamp to the output range.
   logic                    valid6_ff;
   logic [cfa_pkg::ACC_W-1:0] acc6_ff;
   logic                    zone6_ff;
   logic signed [57:0]      sum;
   logic signed [IW-1:0]    acc_sel;
   logic signed [IW-1:0]    acc_clamp;

   always_comb begin
      sum = ($signed(58'(ph5_ff)) <<< TL) + $signed({20'b0, pl5_ff});
      if (zone5_ff) begin
         acc_sel = IW'(za5_ff);
      end else if (zero5_ff) begin
         acc_sel = ACC_FLOOR;
      end else begin
         acc_sel = sum[57:cfa_pkg::FRAC];
      end
      if (acc_sel < ACC_FLOOR) begin
         acc_clamp = ACC_FLOOR;
      end else if (acc_sel > ACC_CAP) begin
         acc_clamp = ACC_CAP;
      end else begin
         acc_clamp = acc_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid6_ff <= 1'b0;
      end else begin
         valid6_ff <= valid5_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc6_ff  <= acc_clamp[cfa_pkg::ACC_W-1:0];
      zone6_ff <= zone5_ff;
   end

   assign out_valid    = valid6_ff;
   assign acceleration = acc6_ff;
   assign in_zone      = zone6_ff;

endmodule

### design/car_following_accel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// car_following_accel
// Per-vehicle car-following acceleration with an indifference zone, Q.16
// fixed point, fully pipelined.
// ----------------------------------------------------------------------------
//  Channel   Ports                          Transfer
//  request   start, busy, req_*             start high while busy low
//  response  rsp_valid, rsp_*               every cycle rsp_valid is high
//  config    csr_we, csr_addr, csr_wdata    every cycle csr_we is high
//
// One vehicle may enter every cycle; its result passes through 4 front
// stages, 31 divider stages, one per quotient bit, and 6 back stages.
// The pipelined ratio divider accounts for most of the latency; throughput is one per cycle.
// busy stays low: the pipeline never stalls, and the receiver cannot stall.
// Synchronous reset clears the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module car_following_accel (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [cfa_pkg::GAP_W-1:0]     req_gap,
   input  logic [cfa_pkg::SPD_W-1:0]     req_speed,
   input  logic [cfa_pkg::SPD_W-1:0]     req_leader_speed,
   input  logic [cfa_pkg::SPD_W-1:0]     req_desired_speed,
   input  logic [cfa_pkg::TS_W-1:0]      req_time_scale,
   input  logic [cfa_pkg::NS_W-1:0]      req_noise_sample,
   output logic                          rsp_valid,
   output logic signed [cfa_pkg::ACC_W-1:0] rsp_acceleration,
   output logic                          rsp_in_zone,
   input  logic                          csr_we,
   input  logic [cfa_pkg::CSR_AW-1:0]    csr_addr,
   input  logic [cfa_pkg::CSR_DW-1:0]    csr_wdata
);

   // Configuration registers.
   cfa_pkg::cfa_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.time_gap           <= cfa_pkg::RST_TIME_GAP;
         cfg_ff.zone_low_time_gap  <= cfa_pkg::RST_ZONE_LOW_GAP;
         cfg_ff.zone_high_time_gap <= cfa_pkg::RST_ZONE_HIGH_GAP;
         cfg_ff.minimum_gap        <= cfa_pkg::RST_MINIMUM_GAP;
         cfg_ff.max_acceleration   <= cfa_pkg::RST_MAX_ACCEL;
         cfg_ff.brake_term         <= cfa_pkg::RST_BRAKE_TERM;
         cfg_ff.noise_gain         <= cfa_pkg::RST_NOISE_GAIN;
         cfg_ff.damping            <= cfa_pkg::RST_DAMPING;
      end else if (csr_we) begin
         case (csr_addr)
            cfa_pkg::REG_TIME_GAP:      cfg_ff.time_gap           <= csr_wdata[15:0];
            cfa_pkg::REG_ZONE_LOW_GAP:  cfg_ff.zone_low_time_gap  <= csr_wdata[15:0];
            cfa_pkg::REG_ZONE_HIGH_GAP: cfg_ff.zone_high_time_gap <= csr_wdata[15:0];
            cfa_pkg::REG_MINIMUM_GAP:   cfg_ff.minimum_gap        <= csr_wdata[25:0];
            cfa_pkg::REG_MAX_ACCEL:     cfg_ff.max_acceleration   <= csr_wdata[19:0];
            cfa_pkg::REG_BRAKE_TERM:    cfg_ff.brake_term         <= csr_wdata[19:0];
            cfa_pkg::REG_NOISE_GAIN:    cfg_ff.noise_gain         <= csr_wdata[23:0];
            cfa_pkg::REG_DAMPING:       cfg_ff.damping            <= csr_wdata[19:0];
            default: begin
            end
         endcase
      end
   end

   // The pipeline takes a transfer in every cycle.
   logic req_take;
   assign busy     = 1'b0;
   assign req_take = start && !busy;

   // Front end.
   logic                  f_valid;
   cfa_pkg::cfa_lane_type f_lane_v, f_lane_s;
   cfa_pkg::cfa_side_type f_side;

   cfa_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .in_valid      (req_take),
      .gap           (req_gap),
      .speed         (req_speed),
      .leader_speed  (req_leader_speed),
      .desired_speed (req_desired_speed),
      .time_scale    (req_time_scale),
      .noise_sample  (req_noise_sample),
      .out_valid     (f_valid),
      .lane_v        (f_lane_v),
      .lane_s        (f_lane_s),
      .side          (f_side)
   );

   // Ratio divider.
   logic                  d_valid;
   cfa_pkg::cfa_lane_type d_lane_v, d_lane_s;
   cfa_pkg::cfa_side_type d_side;

   cfa_div u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (f_valid),
      .in_lane_v  (f_lane_v),
      .in_lane_s  (f_lane_s),
      .in_side    (f_side),
      .out_valid  (d_valid),
      .out_lane_v (d_lane_v),
      .out_lane_s (d_lane_s),
      .out_side   (d_side)
   );

   // Back end.
   logic [cfa_pkg::ACC_W-1:0] b_acc;

   cfa_back u_back (
      .clock            (clock),
      .reset            (reset),
      .max_acceleration (cfg_ff.max_acceleration),
      .in_valid         (d_valid),
      .lane_v           (d_lane_v),
      .lane_s           (d_lane_s),
      .side             (d_side),
      .out_valid        (rsp_valid),
      .acceleration     (b_acc),
      .in_zone          (rsp_in_zone)
   );

   assign rsp_acceleration = $signed(b_acc);

   // Every result traces back to a transfer a fixed latency earlier.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_take, cfa_pkg::PIPE_LAT))
      else $error("result without matching request transfer");

   // Results never fall below the floor of minus nine.
   a_floor : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_acceleration >= -(24'sd9 <<< cfa_pkg::FRAC))
      else $error("acceleration below floor");

endmodule
